[rtl/tcw_pkg.sv]
package tcw_pkg;

  typedef enum logic [2:0] {
    REQ_PUT   = 3'd0,
    REQ_GOTO  = 3'd1,
    REQ_CLEAR = 3'd2,
    REQ_READ  = 3'd3,
    REQ_WRITE = 3'd4
  } req_t;

  localparam logic [2:0] CFG_WIN_LEFT   = 3'd0;
  localparam logic [2:0] CFG_WIN_TOP    = 3'd1;
  localparam logic [2:0] CFG_WIN_RIGHT  = 3'd2;
  localparam logic [2:0] CFG_WIN_BOTTOM = 3'd3;
  localparam logic [2:0] CFG_TEXT_ATTR  = 3'd4;
  localparam logic [2:0] CFG_SCROLL_EN  = 3'd5;

  localparam logic [7:0] CH_BEL = 8'd7;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [6:0] RESET_RIGHT  = 7'd79;
  localparam logic [4:0] RESET_BOTTOM = 5'd24;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

endpackage

[rtl/tcw_ram.sv]
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/text_console_writer_unit.sv]
// Text console writer: keeps a screen of 16-bit cells in one RAM and a cursor relative
// to a configurable window. One request is taken at a time; stall stays high until
// its result word is delivered. A scroll or clear walks the window cell by cell
// through the single RAM port pair: a scroll reads and then writes each cell and
// blanks the bottom row, a clear writes one cell per cycle. Screen address is
// row*SCREEN_COLS+col; the walks step from row to row by adding.
module text_console_writer_unit #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [7:0]  char_code,
  input  logic [6:0]  pos_x,
  input  logic [4:0]  pos_y,
  input  logic [15:0] cell_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic        bell,
  output logic [15:0] read_data
);

  localparam int DEPTH = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW = $clog2(DEPTH);
  localparam logic [6:0] MAX_C = 7'(SCREEN_COLS - 1);
  localparam logic [4:0] MAX_R = 5'(SCREEN_ROWS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SCR_RD, S_SCR_WR, S_FILL, S_OUT
  } state_t;

  state_t state;
  logic [6:0] win_left, win_right;
  logic [4:0] win_top, win_bottom;
  logic [7:0] text_attribute;
  logic       scroll_enable;
  logic [6:0] cur_col;
  logic [4:0] cur_row;
  logic [6:0] wc;
  logic [4:0] wr;
  logic [AW-1:0] row_base;
  logic [4:0] fill_end;

  logic [6:0] el, er, w;
  logic [4:0] et, eb, h;
  logic [6:0] px;
  logic [4:0] py;
  logic [6:0] cc;
  logic [4:0] cr;
  logic [AW-1:0] top_base;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0] ram_wdata, ram_rdata;
  logic        ram_we;
  logic [15:0] blank;

  always_comb begin
    el = (win_left > MAX_C) ? MAX_C : win_left;
    er = (win_right > MAX_C) ? MAX_C : win_right;
    if (er < el) er = el;
    et = (win_top > MAX_R) ? MAX_R : win_top;
    eb = (win_bottom > MAX_R) ? MAX_R : win_bottom;
    if (eb < et) eb = et;
    w = er - el;
    h = eb - et;
    px = (pos_x > w) ? w : pos_x;
    py = (pos_y > h) ? h : pos_y;
    cc = (cur_col > w) ? w : cur_col;
    cr = (cur_row > h) ? h : cur_row;
    blank = {text_attribute, tcw_pkg::CH_SPACE};
  end

  // row start addresses: one multiply by a constant each, narrow
  assign top_base = AW'(32'(et) * SCREEN_COLS);

  logic in_acc;
  logic [AW-1:0] req_addr;
  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    logic [4:0] ry;
    logic [6:0] rx;
    ry = (req_type == tcw_pkg::REQ_PUT) ? cr : py;
    rx = (req_type == tcw_pkg::REQ_PUT) ? cc : px;
    req_addr = AW'((32'(et) + 32'(ry)) * SCREEN_COLS + 32'(el) + 32'(rx));
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = row_base + AW'(el) + AW'(wc);
    ram_wdata = blank;
    ram_raddr = row_base + AW'(SCREEN_COLS) + AW'(el) + AW'(wc);
    if (state == S_IDLE && in_acc) begin
      ram_raddr = req_addr;
      ram_waddr = req_addr;
      if (req_type == tcw_pkg::REQ_WRITE) begin
        ram_we = 1'b1;
        ram_wdata = cell_value;
      end else if (req_type == tcw_pkg::REQ_PUT && char_code != tcw_pkg::CH_CR &&
                   char_code != tcw_pkg::CH_LF && char_code != tcw_pkg::CH_BS &&
                   char_code != tcw_pkg::CH_BEL) begin
        ram_we = 1'b1;
        ram_wdata = {text_attribute, char_code};
      end
    end else if (state == S_SCR_WR) begin
      ram_we = 1'b1;
      ram_wdata = ram_rdata;
    end else if (state == S_FILL) begin
      ram_we = 1'b1;
    end
  end

  tcw_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left <= '0;
      win_top <= '0;
      win_right <= tcw_pkg::RESET_RIGHT;
      win_bottom <= tcw_pkg::RESET_BOTTOM;
      text_attribute <= tcw_pkg::RESET_ATTR;
      scroll_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::CFG_WIN_LEFT:   win_left <= cfg_data[6:0];
        tcw_pkg::CFG_WIN_TOP:    win_top <= cfg_data[4:0];
        tcw_pkg::CFG_WIN_RIGHT:  win_right <= cfg_data[6:0];
        tcw_pkg::CFG_WIN_BOTTOM: win_bottom <= cfg_data[4:0];
        tcw_pkg::CFG_TEXT_ATTR:  text_attribute <= cfg_data;
        tcw_pkg::CFG_SCROLL_EN:  scroll_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cur_col <= '0;
      cur_row <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            bell <= 1'b0;
            read_data <= '0;
            wc <= '0;
            wr <= '0;
            row_base <= top_base;
            state <= S_OUT;
            out_valid <= 1'b1;
            case (req_type)
              tcw_pkg::REQ_PUT: begin
                cur_col <= cc;
                cur_row <= cr;
                if (char_code == tcw_pkg::CH_CR) begin
                  cur_col <= '0;
                end else if (char_code == tcw_pkg::CH_LF) begin
                  if (cr == h) begin
                    if (scroll_enable) begin
                      state <= (h == 0) ? S_FILL : S_SCR_RD;
                      out_valid <= 1'b0;
                      fill_end <= h;
                      if (h == 0) row_base <= top_base;
                    end
                  end else begin
                    cur_row <= cr + 5'd1;
                  end
                end else if (char_code == tcw_pkg::CH_BS) begin
                  if (cc != 0) cur_col <= cc - 7'd1;
                end else if (char_code == tcw_pkg::CH_BEL) begin
                  bell <= 1'b1;
                end else begin
                  if (cc == w) begin
                    cur_col <= '0;
                    if (cr == h) begin
                      if (scroll_enable) begin
                        state <= (h == 0) ? S_FILL : S_SCR_RD;
                        out_valid <= 1'b0;
                        fill_end <= h;
                      end
                    end else begin
                      cur_row <= cr + 5'd1;
                    end
                  end else begin
                    cur_col <= cc + 7'd1;
                  end
                end
              end
              tcw_pkg::REQ_GOTO: begin
                cur_col <= px;
                cur_row <= py;
              end
              tcw_pkg::REQ_CLEAR: begin
                cur_col <= '0;
                cur_row <= '0;
                fill_end <= h;
                state <= S_FILL;
                out_valid <= 1'b0;
              end
              tcw_pkg::REQ_READ: begin
                state <= S_RD;
                out_valid <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          read_data <= ram_rdata;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_SCR_RD: state <= S_SCR_WR;
        S_SCR_WR: begin
          state <= S_SCR_RD;
          if (wc == w) begin
            wc <= '0;
            row_base <= row_base + AW'(SCREEN_COLS);
            if (wr + 5'd1 == h) begin
              wr <= h;
              state <= S_FILL;
            end else begin
              wr <= wr + 5'd1;
            end
          end else begin
            wc <= wc + 7'd1;
          end
        end
        S_FILL: begin
          if (wc == w) begin
            wc <= '0;
            row_base <= row_base + AW'(SCREEN_COLS);
            if (wr == fill_end) begin
              state <= S_OUT;
              out_valid <= 1'b1;
            end else begin
              wr <= wr + 5'd1;
            end
          end else begin
            wc <= wc + 7'd1;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cursor_col = cur_col;
  assign cursor_row = cur_row;

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_OUT)
    else $error("result shown outside output state");
  assert property (@(posedge clk) disable iff (rst) in_acc |=> !in_stall == 1'b0)
    else $error("accepted while busy");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCR_WR) |-> $past(state) == S_SCR_RD)
    else $error("scroll write without read");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(cursor_col) &&
    $stable(cursor_row) && $stable(bell) && $stable(read_data))
    else $error("stalled result word changed");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLS * ROWS;
  localparam longint CYCLE_LIMIT = 10_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  req_type = '0;
  logic [7:0]  char_code = '0;
  logic [6:0]  pos_x = '0;
  logic [4:0]  pos_y = '0;
  logic [15:0] cell_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic        bell;
  logic [15:0] read_data;

  text_console_writer_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .char_code(char_code),
    .pos_x(pos_x), .pos_y(pos_y), .cell_value(cell_value), .out_valid(out_valid),
    .out_stall(out_stall), .cursor_col(cursor_col), .cursor_row(cursor_row),
    .bell(bell), .read_data(read_data)
  );

  always #6 clk = ~clk;

  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic        bell;
    logic [15:0] rd;
  } status_t;

  // shadow screen and window registers
  logic [15:0] scr [CELLS];
  bit          scr_set [CELLS];
  logic [6:0]  w_left, w_right;
  logic [4:0]  w_top, w_bot;
  logic [7:0]  attr;
  logic        scroll_on;
  logic [6:0]  ccol;
  logic [4:0]  crow;
  int          el, er, et, eb;

  status_t expected_q[$];
  int      n_err, n_words, n_sent, n_scrolls, n_clears, n_bells;
  longint  cycles;
  bit      idle_in_en, idle_out_en, hold_out;

  function automatic void calc_win();
    el = (w_left > COLS - 1) ? COLS - 1 : w_left;
    er = (w_right > COLS - 1) ? COLS - 1 : w_right;
    if (er < el) er = el;
    et = (w_top > ROWS - 1) ? ROWS - 1 : w_top;
    eb = (w_bot > ROWS - 1) ? ROWS - 1 : w_bot;
    if (eb < et) eb = et;
  endfunction

  function automatic int addr_of(int r, int c);
    return ((et + r) * COLS + el + c) % CELLS;
  endfunction

  function automatic void put_cell(int r, int c, logic [15:0] v);
    scr[addr_of(r, c)] = v;
    scr_set[addr_of(r, c)] = 1'b1;
  endfunction

  function automatic void scroll_window();
    int w, h;
    w = er - el;
    h = eb - et;
    n_scrolls++;
    for (int r = 0; r < h; r++)
      for (int c = 0; c <= w; c++) begin
        scr[addr_of(r, c)] = scr[addr_of(r + 1, c)];
        scr_set[addr_of(r, c)] = scr_set[addr_of(r + 1, c)];
      end
    for (int c = 0; c <= w; c++) put_cell(h, c, {attr, tcw_pkg::CH_SPACE});
  endfunction

  function automatic status_t console_step(logic [2:0] rq, logic [7:0] ch, logic [6:0] px_in,
                                           logic [4:0] py_in, logic [15:0] val);
    status_t s;
    int w, h, px, py;
    s = '0;
    calc_win();
    w = er - el;
    h = eb - et;
    px = (px_in > w) ? w : px_in;
    py = (py_in > h) ? h : py_in;
    case (rq)
      tcw_pkg::REQ_PUT: begin
        if (ccol > w) ccol = 7'(w);
        if (crow > h) crow = 5'(h);
        if (ch == tcw_pkg::CH_CR) ccol = 0;
        else if (ch == tcw_pkg::CH_LF) begin
          if (crow == h) begin
            if (scroll_on) scroll_window();
          end else crow++;
        end else if (ch == tcw_pkg::CH_BS) begin
          if (ccol != 0) ccol--;
        end else if (ch == tcw_pkg::CH_BEL) begin
          s.bell = 1'b1;
          n_bells++;
        end else begin
          put_cell(crow, ccol, {attr, ch});
          if (ccol + 1 > w) begin
            ccol = 0;
            if (crow + 1 > h) begin
              crow = 5'(h);
              if (scroll_on) scroll_window();
            end else crow++;
          end else ccol++;
        end
      end
      tcw_pkg::REQ_GOTO: begin
        ccol = 7'(px);
        crow = 5'(py);
      end
      tcw_pkg::REQ_CLEAR: begin
        n_clears++;
        for (int r = 0; r <= h; r++)
          for (int c = 0; c <= w; c++) put_cell(r, c, {attr, tcw_pkg::CH_SPACE});
        ccol = 0;
        crow = 0;
      end
      tcw_pkg::REQ_READ: s.rd = scr[addr_of(py, px)];
      tcw_pkg::REQ_WRITE: put_cell(py, px, val);
      default: ;
    endcase
    s.col = ccol;
    s.row = crow;
    return s;
  endfunction

  // true when a read at this window position hits a written cell
  function automatic bit cell_known(logic [6:0] px_in, logic [4:0] py_in);
    int px, py;
    calc_win();
    px = (px_in > er - el) ? er - el : px_in;
    py = (py_in > eb - et) ? eb - et : py_in;
    return scr_set[addr_of(py, px)];
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, expected_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_out || (idle_out_en && $urandom_range(0, 99) < 10);
  end

  always @(posedge clk) begin
    status_t got, exp_s;
    if (!rst && out_valid && !out_stall) begin
      got = '{cursor_col, cursor_row, bell, read_data};
      n_words++;
      if (expected_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected word %h", got);
      end else begin
        exp_s = expected_q.pop_front();
        if (got !== exp_s) begin
          n_err++;
          if (n_err <= 10)
            $display("word %0d: exp col %0d row %0d bell %b rd %h, got col %0d row %0d bell %b rd %h",
                     n_words, exp_s.col, exp_s.row, exp_s.bell, exp_s.rd,
                     got.col, got.row, got.bell, got.rd);
        end
      end
    end
  end

  // valid stays up after acceptance; the next send or drain decides when it drops
  task automatic send_req(logic [2:0] rq, logic [7:0] ch = 8'd65, logic [6:0] px = '0,
                          logic [4:0] py = '0, logic [15:0] val = '0);
    if (idle_in_en && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (idle_in_en && $urandom_range(0, 99) < 10) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    char_code <= ch;
    pos_x <= px;
    pos_y <= py;
    cell_value <= val;
    expected_q.push_back(console_step(rq, ch, px, py, val));
    n_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tcw_pkg::CFG_WIN_LEFT: w_left = val[6:0];
      tcw_pkg::CFG_WIN_TOP: w_top = val[4:0];
      tcw_pkg::CFG_WIN_RIGHT: w_right = val[6:0];
      tcw_pkg::CFG_WIN_BOTTOM: w_bot = val[4:0];
      tcw_pkg::CFG_TEXT_ATTR: attr = val;
      tcw_pkg::CFG_SCROLL_EN: scroll_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_window(int l, int t, int r, int b);
    write_reg(tcw_pkg::CFG_WIN_LEFT, 8'(l));
    write_reg(tcw_pkg::CFG_WIN_TOP, 8'(t));
    write_reg(tcw_pkg::CFG_WIN_RIGHT, 8'(r));
    write_reg(tcw_pkg::CFG_WIN_BOTTOM, 8'(b));
  endtask

  task automatic read_or_write(logic [6:0] px, logic [4:0] py);
    if (cell_known(px, py)) send_req(tcw_pkg::REQ_READ, 8'($urandom), px, py);
    else send_req(tcw_pkg::REQ_WRITE, 8'($urandom), px, py, 16'($urandom));
  endtask

  task automatic test_directed();
    send_req(tcw_pkg::REQ_CLEAR);
    send_req(tcw_pkg::REQ_PUT, 8'hFF);
    send_req(tcw_pkg::REQ_PUT, 8'h00);
    send_req(tcw_pkg::REQ_PUT, tcw_pkg::CH_BEL);
    send_req(tcw_pkg::REQ_PUT, tcw_pkg::CH_BS);
    send_req(tcw_pkg::REQ_PUT, tcw_pkg::CH_BS);
    send_req(tcw_pkg::REQ_PUT, tcw_pkg::CH_BS);
    send_req(tcw_pkg::REQ_PUT, tcw_pkg::CH_CR);
    send_req(tcw_pkg::REQ_PUT, tcw_pkg::CH_LF);
    send_req(tcw_pkg::REQ_READ, 8'd0, 7'd0, 5'd0);
    send_req(tcw_pkg::REQ_READ, 8'd0, 7'd1, 5'd0);
    send_req(tcw_pkg::REQ_WRITE, 8'd0, 7'd79, 5'd24, 16'hFFFF);
    send_req(tcw_pkg::REQ_READ, 8'd0, 7'd127, 5'd31);
    send_req(tcw_pkg::REQ_WRITE, 8'd0, 7'd0, 5'd0, 16'h0000);
    send_req(tcw_pkg::REQ_GOTO, 8'd0, 7'd127, 5'd31);
    send_req(tcw_pkg::REQ_PUT, 8'h5A);
    send_req(tcw_pkg::REQ_GOTO, 8'd0, 7'd3, 5'd24);
    send_req(tcw_pkg::REQ_PUT, tcw_pkg::CH_LF);
    send_req(tcw_pkg::REQ_READ, 8'd0, 7'd79, 5'd23);
    send_req(3'd5, 8'hAA, 7'h55, 5'h15, 16'h5555);
    send_req(3'd6);
    send_req(3'd7, 8'd0, 7'h2A, 5'h0A, 16'hAAAA);
  endtask

  task automatic test_window_edges();
    write_reg(tcw_pkg::CFG_SCROLL_EN, 8'd0);
    write_reg(tcw_pkg::CFG_TEXT_ATTR, 8'hFF);
    set_window(70, 20, 79, 24);
    send_req(tcw_pkg::REQ_CLEAR);
    send_req(tcw_pkg::REQ_GOTO, 8'd0, 7'd9, 5'd4);
    send_req(tcw_pkg::REQ_PUT, 8'h41);
    send_req(tcw_pkg::REQ_PUT, tcw_pkg::CH_LF);
    send_req(tcw_pkg::REQ_READ, 8'd0, 7'd9, 5'd4);
    write_reg(tcw_pkg::CFG_SCROLL_EN, 8'd1);
    send_req(tcw_pkg::REQ_PUT, 8'h42);
    for (int c = 0; c < 10; c++) send_req(tcw_pkg::REQ_PUT, 8'(8'h43 + c));
    send_req(tcw_pkg::REQ_READ, 8'd0, 7'd0, 5'd3);
    // out-of-range and inverted windows
    set_window(8'hFF, 8'hFF, 8'h00, 8'h00);
    send_req(tcw_pkg::REQ_PUT, 8'h44);
    send_req(tcw_pkg::REQ_PUT, tcw_pkg::CH_LF);
    send_req(tcw_pkg::REQ_READ, 8'd0, 7'd5, 5'd5);
    set_window(10, 5, 10, 5);
    write_reg(tcw_pkg::CFG_TEXT_ATTR, 8'h00);
    send_req(tcw_pkg::REQ_CLEAR);
    send_req(tcw_pkg::REQ_PUT, 8'h45);
    send_req(tcw_pkg::REQ_READ);
    set_window(0, 0, 79, 24);
  endtask

  task automatic random_mix(int n);
    int k, p;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        p = $urandom_range(0, 9);
        send_req(tcw_pkg::REQ_PUT, p == 0 ? tcw_pkg::CH_CR : p == 1 ? tcw_pkg::CH_LF :
                 p == 2 ? tcw_pkg::CH_BS : p == 3 ? tcw_pkg::CH_BEL : 8'($urandom));
      end else if (k < 65) begin
        send_req(tcw_pkg::REQ_GOTO, 8'($urandom), 7'($urandom), 5'($urandom));
      end else if (k < 67) send_req(tcw_pkg::REQ_CLEAR, 8'($urandom));
      else if (k < 95) read_or_write(7'($urandom), 5'($urandom));
      else send_req(3'($urandom_range(5, 7)), 8'($urandom), 7'($urandom), 5'($urandom),
                    16'($urandom));
    end
  endtask

  task automatic test_random();
    int l, t;
    idle_in_en = 1'b1;
    idle_out_en = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      l = $urandom_range(0, 79);
      t = $urandom_range(0, 24);
      // mostly small windows so scrolls stay short
      set_window(l, t, ph == 4 ? 79 : l + $urandom_range(0, 12),
                 ph == 4 ? 24 : t + $urandom_range(0, 5));
      write_reg(tcw_pkg::CFG_TEXT_ATTR, 8'($urandom));
      write_reg(tcw_pkg::CFG_SCROLL_EN, 8'($urandom));
      send_req(tcw_pkg::REQ_CLEAR);
      random_mix(ph == 2 ? 30 : 55);
      if (ph == 1) begin
        idle_in_en = 1'b0;
        idle_out_en = 1'b0;
      end
      if (ph == 3) begin
        idle_in_en = 1'b1;
        idle_out_en = 1'b1;
      end
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_req(tcw_pkg::REQ_PUT, 8'(8'h30 + i));
    join
  endtask

  initial begin
    w_left = 0; w_top = 0; w_right = tcw_pkg::RESET_RIGHT; w_bot = tcw_pkg::RESET_BOTTOM;
    attr = tcw_pkg::RESET_ATTR; scroll_on = 1'b1; ccol = 0; crow = 0;
    for (int i = 0; i < CELLS; i++) begin
      scr[i] = '0;
      scr_set[i] = 1'b0;
    end
    n_err = 0; n_words = 0; n_sent = 0; n_scrolls = 0; n_clears = 0; n_bells = 0;
    cycles = 0; idle_in_en = 0; idle_out_en = 0; hold_out = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_window_edges();
    test_backpressure();
    test_random();
    drain();
    if (expected_q.size() != 0) n_err++;
    $display("sent %0d requests, checked %0d words, %0d errors", n_sent, n_words, n_err);
    $display("scrolls %0d, clears %0d, bells %0d across several windows and attributes",
             n_scrolls, n_clears, n_bells);
    if (n_err == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
